/* sv/met_pkg.sv */
// ----------------------------------------------------------------------------
// met_pkg
// Types shared by the escape-time unit: request and result payloads,
// sequencer states and the core status bundle.
// ----------------------------------------------------------------------------
package met_pkg;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } t_in_req;

    typedef struct packed {
        logic [23:0] grey_colour;
        logic [7:0]  iteration_count;
        logic        escaped;
    } t_out_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_XX,
        S_MUL_YY,
        S_MUL_XY,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
            r = v[31:0];
        end else if (v[63]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

/* sv/met_core.sv */
// ----------------------------------------------------------------------------
// met_core
// Sequencer and datapath for z = z*z + c around one shared 32x32 signed
// multiplier: x*x, y*y, x*y in turn, then escape test and update.
// ----------------------------------------------------------------------------
module met_core #(
    parameter int FRAC_BITS = 28
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  met_pkg::t_in_req    i_req,
    input  logic [7:0]          i_max_iter,
    input  logic                i_take,
    output met_pkg::t_core_sts  o_sts,
    output met_pkg::t_out_rsp   o_rsp
);
    import met_pkg::*;

    localparam logic [63:0] FOUR = 64'd4 << (2 * FRAC_BITS);

    t_state r_state, n_state;

    logic signed [31:0] r_cr, r_ci;
    logic signed [31:0] r_zr, r_zi;
    logic [7:0]         r_count;
    logic               r_esc;
    logic signed [63:0] r_xx, r_yy, r_xy, r_diff;
    logic [63:0]        r_mag;

    logic signed [31:0] w_mul_a, w_mul_b;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_re_sum, w_im_sum;
    logic               w_escape, w_limit;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_MUL_XX: begin
                w_mul_a = r_zr;
                w_mul_b = r_zr;
            end
            S_MUL_YY: begin
                w_mul_a = r_zi;
                w_mul_b = r_zi;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
        endcase
    end

    assign w_prod   = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_re_sum = (r_diff >>> FRAC_BITS) + 64'(r_cr);
    assign w_im_sum = (r_xy >>> (FRAC_BITS - 1)) + 64'(r_ci);
    assign w_escape = (r_mag >= FOUR);
    assign w_limit  = (r_count >= i_max_iter);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL_XX;
                end
            end
            S_MUL_XX: n_state = S_MUL_YY;
            S_MUL_YY: n_state = S_MUL_XY;
            S_MUL_XY: n_state = S_EVAL;
            S_EVAL: begin
                if (w_escape || w_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_XX;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_cr    <= i_req.c_real;
                    r_ci    <= i_req.c_imag;
                    r_zr    <= '0;
                    r_zi    <= '0;
                    r_count <= '0;
                    r_esc   <= 1'b0;
                end
            end
            S_MUL_XX: r_xx <= w_prod;
            S_MUL_YY: r_yy <= w_prod;
            S_MUL_XY: begin
                r_xy   <= w_prod;
                r_mag  <= $unsigned(r_xx) + $unsigned(r_yy);
                r_diff <= r_xx - r_yy;
            end
            S_EVAL: begin
                if (w_escape) begin
                    r_esc <= 1'b1;
                end else if (!w_limit) begin
                    r_zr    <= sat32(w_re_sum);
                    r_zi    <= sat32(w_im_sum);
                    r_count <= r_count + 8'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.idle            = (r_state == S_IDLE);
    assign o_sts.done            = (r_state == S_DONE);
    assign o_rsp.grey_colour     = {r_count, r_count, r_count};
    assign o_rsp.iteration_count = r_count;
    assign o_rsp.escaped         = r_esc;

endmodule

/* sv/mandelbrot_escape_time_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time iteration for one Q4.28 point per request, with an APB
// register for the iteration limit and a registered result stage.
// ----------------------------------------------------------------------------
// Each iteration runs the shared 32x32 multiplier through three products
// and then one escape test / update step. A new request is taken once the
// previous result has moved into the output register.
module mandelbrot_escape_time_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  met_pkg::t_in_req   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output met_pkg::t_out_rsp  o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import met_pkg::*;

    localparam logic REG_MAX_ITER = 1'b0;

    logic [7:0]  r_max_iter;
    logic        r_out_valid;
    t_out_rsp    r_out_data;

    t_core_sts   w_sts;
    t_out_rsp    w_rsp;
    logic        w_start, w_take, w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_ITER) ? {24'd0, r_max_iter} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= 8'd255;
        end else if (w_wr && paddr[2] == REG_MAX_ITER) begin
            r_max_iter <= pwdata[7:0];
        end
    end

    assign o_in_ready = w_sts.idle;
    assign w_start    = i_in_valid && w_sts.idle;
    assign w_take     = !r_out_valid || i_out_ready;

    met_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (i_in_data),
        .i_max_iter (r_max_iter),
        .i_take     (w_take),
        .o_sts      (w_sts),
        .o_rsp      (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done && w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done && w_take) begin
            r_out_data <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted but unit still ready");

    a_inside_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.escaped |-> o_out_data.iteration_count == r_max_iter)
        else $error("inside result with count other than the limit");

    a_escape_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.escaped |->
            o_out_data.iteration_count <= r_max_iter && o_out_data.iteration_count != 8'd0)
        else $error("escape count out of range");

    a_grey_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.grey_colour ==
            {o_out_data.iteration_count, o_out_data.iteration_count,
             o_out_data.iteration_count})
        else $error("grey colour does not match count");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mandelbrot_escape_time_unit. Points go in through a
// bursty valid/ready driver, results are checked in order against a
// bit-exact escape-time predictor, and the iteration limit is reprogrammed
// over APB between phases, including zero, one and the top value.
// ----------------------------------------------------------------------------
module tb_top;
    import met_pkg::*;

    localparam int          FRAC_BITS     = 28;
    localparam logic [63:0] FOUR_Q        = 64'd4 << (2 * FRAC_BITS);
    localparam longint      Q_MAX         = 64'sd2147483647;
    localparam longint      Q_MIN         = -64'sd2147483648;
    localparam logic [2:0]  MAX_ITER_ADDR = 3'd0;
    localparam int          HOLD_AFTER    = 200;
    localparam int          HOLD_CYCLES   = 2000;
    localparam int          PHASE_POINTS  = 150;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_req     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_rsp    out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    t_in_req     point_queue[$];
    t_out_rsp    escape_queue[$];
    logic [7:0]  iter_limit = 8'd255;
    int          errors     = 0;

    int          gap_left;
    int          burst_left;
    t_rx_mode    rx_mode;
    int          mode_left;
    int          hold_left;
    int          rx_seen;
    logic        hold_done;

    mandelbrot_escape_time_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic logic signed [31:0] clamp_q(input longint v);
        if (v > Q_MAX) begin
            return 32'sh7fff_ffff;
        end else if (v < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_out_rsp escape_time(input logic signed [31:0] cr,
                                             input logic signed [31:0] ci,
                                             input logic [7:0]         lim);
        longint      x;
        longint      y;
        longint      xx;
        longint      yy;
        longint      xy;
        logic [63:0] mag;
        logic [7:0]  n;
        logic        esc;
        logic        done;
        t_out_rsp    r;
        x    = 0;
        y    = 0;
        n    = '0;
        esc  = 1'b0;
        done = 1'b0;
        while (!done) begin
            xx  = x * x;
            yy  = y * y;
            mag = xx + yy;
            if (mag >= FOUR_Q) begin
                esc  = 1'b1;
                done = 1'b1;
            end else if (n >= lim) begin
                done = 1'b1;
            end else begin
                xy = x * y;
                x  = clamp_q(((xx - yy) >>> FRAC_BITS) + cr);
                y  = clamp_q((xy >>> (FRAC_BITS - 1)) + ci);
                n  = n + 8'd1;
            end
        end
        r.grey_colour     = 24'(n) * 24'h01_0101;
        r.iteration_count = n;
        r.escaped         = esc;
        return r;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (in_valid && in_ready) begin
                escape_queue.push_back(escape_time(in_data.c_real, in_data.c_imag,
                                                   iter_limit));
            end
            if (in_valid && !in_ready) begin
                // hold the request until taken
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (point_queue.size() > 0) begin
                in_data  <= point_queue.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the unit
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_mode   = RX_ALWAYS;
            mode_left = 0;
            hold_left = 0;
            rx_seen   = 0;
            hold_done = 1'b0;
        end else begin
            if (out_ready && out_valid) begin
                rx_seen++;
            end
            if (!hold_done && rx_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        out_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk) begin
        t_out_rsp want;
        if (rst_n && out_valid && out_ready) begin
            if (escape_queue.size() == 0) begin
                $error("unexpected result: count %0d escaped %0d",
                       out_data.iteration_count, out_data.escaped);
                errors++;
            end else begin
                want = escape_queue.pop_front();
                if (out_data.grey_colour !== want.grey_colour) begin
                    $error("grey_colour mismatch: expected %h, got %h",
                           want.grey_colour, out_data.grey_colour);
                    errors++;
                end
                if (out_data.iteration_count !== want.iteration_count) begin
                    $error("iteration_count mismatch: expected %0d, got %0d",
                           want.iteration_count, out_data.iteration_count);
                    errors++;
                end
                if (out_data.escaped !== want.escaped) begin
                    $error("escaped mismatch: expected %0d, got %0d",
                           want.escaped, out_data.escaped);
                    errors++;
                end
            end
        end
    end

    task automatic queue_point(input logic [31:0] cr, input logic [31:0] ci);
        t_in_req p;
        p.c_real = cr;
        p.c_imag = ci;
        point_queue.push_back(p);
    endtask

    task automatic queue_random_points(input int count);
        t_in_req p;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9)) inside
                [0:3]: begin
                    // around the set, real -2..0.5, imag -1.25..1.25
                    p.c_real = 32'($urandom_range(0, 671088640)) - 32'd536870912;
                    p.c_imag = 32'($urandom_range(0, 671088640)) - 32'd335544320;
                end
                [4:5]: begin
                    // main cardioid and its edge
                    p.c_real = 32'($urandom_range(0, 201326592)) - 32'd134217728;
                    p.c_imag = 32'($urandom_range(0, 268435456)) - 32'd134217728;
                end
                6: begin
                    p.c_real = $signed($urandom) >>> $urandom_range(0, 31);
                    p.c_imag = $signed($urandom) >>> $urandom_range(0, 31);
                end
                default: begin
                    p.c_real = $urandom;
                    p.c_imag = $urandom;
                end
            endcase
            point_queue.push_back(p);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge clk);
        end while (point_queue.size() != 0 || in_valid || escape_queue.size() != 0);
    endtask

    task automatic set_iter_limit(input logic [7:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_ITER_ADDR;
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        readback = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {24'h0, value}) begin
            $error("max_iterations readback mismatch: expected %h, got %h",
                   {24'h0, value}, readback);
            errors++;
        end
        iter_limit = value;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // corner points at the reset limit
        queue_point(32'h0000_0000, 32'h0000_0000);
        queue_point(32'h7fff_ffff, 32'h7fff_ffff);
        queue_point(32'h8000_0000, 32'h8000_0000);
        queue_point(32'h8000_0000, 32'h7fff_ffff);
        queue_point(32'h7fff_ffff, 32'h0000_0000);
        queue_point(32'h0000_0000, 32'h8000_0000);
        queue_point(32'he000_0000, 32'h0000_0000);
        queue_point(32'h2000_0000, 32'h0000_0000);
        queue_point(32'h0000_0000, 32'h2000_0000);
        queue_point(32'h0000_0000, 32'he000_0000);
        queue_point(32'h1fff_ffff, 32'h0000_0000);
        queue_point(32'he000_0001, 32'h0000_0000);
        queue_point(32'h0400_0000, 32'h0000_0000);
        queue_point(32'h0428_f5c2, 32'h0000_0000);
        queue_point(32'hf400_0000, 32'h0199_999a);
        queue_point(32'hf000_0000, 32'h0000_0000);
        queue_point(32'h0000_0000, 32'h1000_0000);
        queue_point(32'hf000_0000, 32'h1000_0000);
        queue_point(32'h0800_0000, 32'h0800_0000);
        queue_point(32'hffff_ffff, 32'hffff_ffff);
        queue_point(32'h0000_0001, 32'h0000_0001);
        wait_drained();

        set_iter_limit(8'd0);
        queue_random_points(PHASE_POINTS);
        wait_drained();

        set_iter_limit(8'd1);
        queue_random_points(PHASE_POINTS);
        wait_drained();

        set_iter_limit(8'd255);
        queue_random_points(PHASE_POINTS);
        wait_drained();

        set_iter_limit(8'($urandom_range(2, 40)));
        queue_random_points(PHASE_POINTS);
        wait_drained();

        set_iter_limit(8'd254);
        queue_random_points(PHASE_POINTS);
        wait_drained();

        set_iter_limit(8'($urandom_range(1, 255)));
        queue_random_points(PHASE_POINTS);
        wait_drained();

        repeat (50) @(posedge clk);
        if (errors == 0) begin
            $display("mandelbrot_escape_time_unit test passed");
        end else begin
            $display("mandelbrot_escape_time_unit test failed");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("mandelbrot_escape_time_unit test failed");
        $finish;
    end

endmodule
